// ----- sv/segment_range_tracker_top_assert.svh -----
// Assertion macros for the segment range tracker.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEGMENT_RANGE_TRACKER_TOP_ASSERT_SVH
`define SEGMENT_RANGE_TRACKER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SRT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("segment range tracker: same-cycle check failed");
`define SRT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("segment range tracker: next-cycle check failed");
`else
`define SRT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SRT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/srt_pkg.sv -----
// Shared constants and types for the segment range tracker.
// No dependencies; used by the interfaces, the range cell and the top level.
package srt_pkg;

    localparam int DATA_W          = 32;
    localparam int HELD_W          = 6;
    localparam int DEF_MAX_RANGES  = 32;

    localparam logic [2:0] ST_PENDING  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_OVERLAP  = 3'd3;
    localparam logic [2:0] ST_LENGTH   = 3'd4;
    localparam logic [2:0] ST_TARGET   = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;
    localparam logic [2:0] ST_CLEARED  = 3'd7;

    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_INSERT = 3'd2;
    localparam logic [2:0] OP_BOTH   = 3'd3;
    localparam logic [2:0] OP_LEFT   = 3'd4;
    localparam logic [2:0] OP_RIGHT  = 3'd5;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              check;
        logic [2:0]        op;
        logic [DATA_W-1:0] off;
        logic [DATA_W-1:0] seg_end;
    } cell_cmd_t;

    // what a cell shows its neighbors
    typedef struct packed {
        logic              p;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] fin;
    } cell_link_t;

    // per-cell hits, OR-reduced by the controller
    typedef struct packed {
        logic dup;
        logic ovl;
        logic lhit;
        logic rhit;
    } cell_flags_t;

endpackage

// ----- sv/srt_if.sv -----
// Valid/ready channel interfaces for segment requests and results.
// Depends on srt_pkg for field widths.
interface srt_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [srt_pkg::DATA_W-1:0] target_id;
    logic [srt_pkg::DATA_W-1:0] seg_offset;
    logic [srt_pkg::DATA_W-1:0] seg_length;
    logic [srt_pkg::DATA_W-1:0] total_length;

    modport source (output valid, req_type, target_id, seg_offset, seg_length, total_length,
                    input ready);
    modport sink   (input valid, req_type, target_id, seg_offset, seg_length, total_length,
                    output ready);
endinterface

interface srt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 status;
    logic [srt_pkg::DATA_W-1:0] received_bytes;
    logic [srt_pkg::HELD_W-1:0] ranges_held;

    modport source (output valid, status, received_bytes, ranges_held, input ready);
    modport sink   (input valid, status, received_bytes, ranges_held, output ready);
endinterface

// ----- sv/segment_range_tracker_top.sv -----
// Segment range tracker: one request in, one status result out, taken only when idle; a request
// passes through accept, cell compare, flag reduction, and decide and update, and the result is
// registered when decide fires. The range cells compare in parallel and shift by one slot.
// A new request is taken while an earlier result waits; a stalled result holds the decide cycle.
// Reset (rst_n low, asynchronous) leaves the tracker idle with zero counts; range slots
// are not cleared.
module segment_range_tracker_top #(
    parameter int MAX_RANGES = srt_pkg::DEF_MAX_RANGES
) (
    input  logic          clk,
    input  logic          rst_n,
    srt_req_if.sink       request,
    srt_rsp_if.source     result
);

`include "segment_range_tracker_top_assert.svh"

    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int DW = srt_pkg::DATA_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_REDUCE = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic          type_reg;
    logic [DW-1:0] tid_reg, off_reg, len_reg, tot_reg;
    logic [DW:0]   seg_end_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [DW-1:0] exp_reg, exp_next;
    logic [DW-1:0] bytes_reg, bytes_next;
    logic [DW-1:0] tgt_reg, tgt_next;
    logic [DW-1:0] last_end_reg, last_end_next;
    logic          busy_reg, busy_next;

    logic any_dup_reg, any_ovl_reg, any_l_reg, any_r_reg;
    logic any_dup, any_ovl, any_l, any_r;

    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [DW-1:0] rbytes_reg;
    logic [srt_pkg::HELD_W-1:0] rheld_reg;

    logic          stall, fire;
    logic [2:0]    status_d, op_d;
    logic          bad;
    logic [DW-1:0] newtot, bytes_sum;
    logic [DW:0]   newtot_x;

    srt_pkg::cell_cmd_t   cmd;
    srt_pkg::cell_link_t  links [MAX_RANGES];
    srt_pkg::cell_flags_t cflags [MAX_RANGES];
    srt_pkg::cell_link_t  edge_lo, edge_hi;

    assign request.ready = state_reg == S_IDLE;
    assign stall = out_valid_reg && !result.ready;
    assign fire  = (state_reg == S_DECIDE) && !stall;

    assign edge_lo = '{p: 1'b0, start: '0, fin: '0};
    assign edge_hi = '{p: 1'b1, start: '0, fin: '0};

    assign cmd.check   = state_reg == S_CHECK;
    assign cmd.op      = fire ? op_d : srt_pkg::OP_NONE;
    assign cmd.off     = off_reg;
    assign cmd.seg_end = seg_end_reg[DW-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_RANGES; gi++)
        begin : g_cell
            srt_pkg::cell_link_t prv, nxt;
            if (gi == 0)
            begin : g_lo
                assign prv = edge_lo;
            end
            else
            begin : g_lo
                assign prv = links[gi-1];
            end
            if (gi == MAX_RANGES - 1)
            begin : g_hi
                assign nxt = edge_hi;
            end
            else
            begin : g_hi
                assign nxt = links[gi+1];
            end
            srt_cell #(.IDX(gi), .CNT_W(CW)) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .count (count_reg),
                .prev  (prv),
                .next  (nxt),
                .link  (links[gi]),
                .flags (cflags[gi])
            );
        end
    endgenerate

    always_comb
    begin
        any_dup = 1'b0;
        any_ovl = 1'b0;
        any_l   = 1'b0;
        any_r   = 1'b0;
        for (int i = 0; i < MAX_RANGES; i++)
        begin
            any_dup = any_dup | cflags[i].dup;
            any_ovl = any_ovl | cflags[i].ovl;
            any_l   = any_l   | cflags[i].lhit;
            any_r   = any_r   | cflags[i].rhit;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   state_next = request.valid ? S_CHECK : S_IDLE;
            S_CHECK:  state_next = S_REDUCE;
            S_REDUCE: state_next = S_DECIDE;
            S_DECIDE: state_next = stall ? S_DECIDE : S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign bad       = (len_reg == '0) || seg_end_reg[DW];
    assign newtot    = (exp_reg != '0) ? exp_reg : tot_reg;
    assign newtot_x  = {1'b0, newtot};
    assign bytes_sum = bytes_reg + len_reg;

    always_comb
    begin
        status_d      = srt_pkg::ST_PENDING;
        op_d          = srt_pkg::OP_NONE;
        count_next    = count_reg;
        exp_next      = exp_reg;
        bytes_next    = bytes_reg;
        tgt_next      = tgt_reg;
        last_end_next = last_end_reg;
        busy_next     = busy_reg;
        if (type_reg == srt_pkg::REQ_CLEAR)
        begin
            status_d   = srt_pkg::ST_CLEARED;
            count_next = '0;
            exp_next   = '0;
            bytes_next = '0;
            tgt_next   = '0;
            busy_next  = 1'b0;
        end
        else if (!busy_reg)
        begin
            if (bad || ((tot_reg != '0) && (seg_end_reg > {1'b0, tot_reg})))
                status_d = srt_pkg::ST_LENGTH;
            else
            begin
                op_d          = srt_pkg::OP_START;
                count_next    = CW'(1);
                bytes_next    = len_reg;
                exp_next      = tot_reg;
                tgt_next      = tid_reg;
                last_end_next = seg_end_reg[DW-1:0];
                if ((tot_reg != '0) && (len_reg == tot_reg))
                begin
                    busy_next = 1'b0;
                    status_d  = srt_pkg::ST_COMPLETE;
                end
                else
                    busy_next = 1'b1;
            end
        end
        else if (tid_reg != tgt_reg)
            status_d = srt_pkg::ST_TARGET;
        else if ((exp_reg != '0) && (tot_reg != exp_reg))
            status_d = srt_pkg::ST_LENGTH;
        else if (bad)
            status_d = srt_pkg::ST_LENGTH;
        else if ((newtot != '0) && ((seg_end_reg > newtot_x) || (last_end_reg > newtot)))
            status_d = srt_pkg::ST_LENGTH;
        else if (any_dup_reg)
            status_d = srt_pkg::ST_DUP;
        else if (any_ovl_reg)
            status_d = srt_pkg::ST_OVERLAP;
        else if (!any_l_reg && !any_r_reg && (count_reg >= CW'(MAX_RANGES)))
            status_d = srt_pkg::ST_FULL;
        else
        begin
            exp_next   = newtot;
            bytes_next = bytes_sum;
            // merges only ever extend, so the last end is the larger of the two
            if (seg_end_reg[DW-1:0] > last_end_reg)
                last_end_next = seg_end_reg[DW-1:0];
            if (any_l_reg && any_r_reg)
            begin
                op_d       = srt_pkg::OP_BOTH;
                count_next = count_reg - CW'(1);
            end
            else if (any_l_reg)
                op_d = srt_pkg::OP_LEFT;
            else if (any_r_reg)
                op_d = srt_pkg::OP_RIGHT;
            else
            begin
                op_d       = srt_pkg::OP_INSERT;
                count_next = count_reg + CW'(1);
            end
            if ((newtot != '0) && (bytes_sum == newtot))
            begin
                busy_next = 1'b0;
                status_d  = srt_pkg::ST_COMPLETE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            exp_reg       <= '0;
            bytes_reg     <= '0;
            tgt_reg       <= '0;
            last_end_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            any_dup_reg   <= 1'b0;
            any_ovl_reg   <= 1'b0;
            any_l_reg     <= 1'b0;
            any_r_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_REDUCE)
            begin
                any_dup_reg <= any_dup;
                any_ovl_reg <= any_ovl;
                any_l_reg   <= any_l;
                any_r_reg   <= any_r;
            end
            if (fire)
            begin
                count_reg    <= count_next;
                exp_reg      <= exp_next;
                bytes_reg    <= bytes_next;
                tgt_reg      <= tgt_next;
                last_end_reg <= last_end_next;
                busy_reg     <= busy_next;
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            type_reg    <= request.req_type;
            tid_reg     <= request.target_id;
            off_reg     <= request.seg_offset;
            len_reg     <= request.seg_length;
            tot_reg     <= request.total_length;
            seg_end_reg <= {1'b0, request.seg_offset} + {1'b0, request.seg_length};
        end
        if (fire)
        begin
            status_reg <= status_d;
            rbytes_reg <= bytes_next;
            rheld_reg  <= srt_pkg::HELD_W'(count_next);
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = status_reg;
    assign result.received_bytes = rbytes_reg;
    assign result.ranges_held    = rheld_reg;

    `SRT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_RANGES))
    `SRT_ASSERT_IMP(a_busy_holds, clk, rst_n, busy_reg, count_reg != '0)
    `SRT_ASSERT_IMP(a_bytes_below, clk, rst_n, busy_reg && (exp_reg != '0), bytes_reg < exp_reg)
    `SRT_ASSERT_NXT(a_decide_done, clk, rst_n, fire, (state_reg == S_IDLE) && out_valid_reg)

endmodule

// ----- sv/srt_cell.sv -----
// One range slot of the sorted range chain: holds [start, end) and its compare flags.
// Depends on srt_pkg; instantiated in a row by segment_range_tracker_top.
module srt_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  srt_pkg::cell_cmd_t   cmd,
    input  logic [CNT_W-1:0]     count,
    input  srt_pkg::cell_link_t  prev,
    input  srt_pkg::cell_link_t  next,
    output srt_pkg::cell_link_t  link,
    output srt_pkg::cell_flags_t flags
);

    logic [srt_pkg::DATA_W-1:0] start_reg, start_next;
    logic [srt_pkg::DATA_W-1:0] end_reg, end_next;
    logic p_reg, v_reg, dup_reg, ovl_reg, endeq_reg, starteq_reg;
    logic v_now, gt_now;
    logic at_pos, left_role;

    assign v_now  = CNT_W'(IDX) < count;
    assign gt_now = start_reg > cmd.off;

    // p: this slot sits at or beyond the insertion point
    assign at_pos    = p_reg && !prev.p;
    assign left_role = !p_reg && next.p;

    assign link.p     = p_reg;
    assign link.start = start_reg;
    assign link.fin   = end_reg;

    assign flags.dup  = dup_reg;
    assign flags.ovl  = ovl_reg;
    assign flags.lhit = left_role && endeq_reg;
    assign flags.rhit = at_pos && v_reg && starteq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg       <= 1'b0;
            v_reg       <= 1'b0;
            dup_reg     <= 1'b0;
            ovl_reg     <= 1'b0;
            endeq_reg   <= 1'b0;
            starteq_reg <= 1'b0;
        end
        else if (cmd.check)
        begin
            p_reg       <= !v_now || gt_now;
            v_reg       <= v_now;
            dup_reg     <= v_now && (start_reg <= cmd.off) && (cmd.seg_end <= end_reg);
            ovl_reg     <= v_now && (cmd.off < end_reg) && (start_reg < cmd.seg_end);
            endeq_reg   <= v_now && (end_reg == cmd.off);
            starteq_reg <= start_reg == cmd.seg_end;
        end
    end

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        case (cmd.op)
            srt_pkg::OP_START:
            begin
                if (IDX == 0)
                begin
                    start_next = cmd.off;
                    end_next   = cmd.seg_end;
                end
            end
            srt_pkg::OP_INSERT:
            begin
                if (at_pos)
                begin
                    start_next = cmd.off;
                    end_next   = cmd.seg_end;
                end
                else if (p_reg)
                begin
                    start_next = prev.start;
                    end_next   = prev.fin;
                end
            end
            srt_pkg::OP_BOTH:
            begin
                // left slot absorbs the right one; the tail moves down by one
                if (left_role)
                    end_next = next.fin;
                else if (p_reg)
                begin
                    start_next = next.start;
                    end_next   = next.fin;
                end
            end
            srt_pkg::OP_LEFT:
            begin
                if (left_role)
                    end_next = cmd.seg_end;
            end
            srt_pkg::OP_RIGHT:
            begin
                if (at_pos)
                    start_next = cmd.off;
            end
            default:
            begin
                start_next = start_reg;
                end_next   = end_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

endmodule

// ----- tb/sv/reassembly_tb_pkg.sv -----
// Transaction types and the scoreboard for the segment range tracker bench.
// Depends on srt_pkg for status codes, request codes and field widths.
// The scoreboard predicts each status result and checks results in order.
package reassembly_tb_pkg;

    import srt_pkg::*;

    localparam int MAX_SLOTS = DEF_MAX_RANGES;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] target_id;
        logic [DATA_W-1:0] seg_offset;
        logic [DATA_W-1:0] seg_length;
        logic [DATA_W-1:0] total_length;
    } seg_req_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [DATA_W-1:0] received_bytes;
        logic [HELD_W-1:0] ranges_held;
    } seg_rsp_t;

    class reassembly_scoreboard;

        // tracker state as the predictor sees it
        bit [DATA_W-1:0] starts [MAX_SLOTS];
        bit [DATA_W-1:0] sizes  [MAX_SLOTS];
        int unsigned     held;
        bit [DATA_W-1:0] known_total;
        bit [DATA_W-1:0] collected;
        bit [DATA_W-1:0] owner;
        bit              active;

        seg_rsp_t        due_results [$];
        int unsigned     errors;

        function longint unsigned end_at(int unsigned idx);
            return {32'd0, starts[idx]} + {32'd0, sizes[idx]};
        endfunction

        function seg_rsp_t snapshot(logic [2:0] code);
            seg_rsp_t r;
            r.status         = code;
            r.received_bytes = collected;
            r.ranges_held    = HELD_W'(held);
            return r;
        endfunction

        // Apply one request to the tracker state; returns the status it reports.
        function seg_rsp_t track_segment(seg_req_t r);
            longint unsigned seg_end;
            longint unsigned s;
            longint unsigned e;
            bit [DATA_W-1:0] new_total;
            int unsigned     slot;
            int unsigned     i;
            bit              bad;
            bit              left;
            bit              right;

            seg_end = {32'd0, r.seg_offset} + {32'd0, r.seg_length};
            bad     = (r.seg_length == 0) || (seg_end > 64'hFFFF_FFFF);

            if (r.req_type == REQ_CLEAR)
            begin
                active      = 1'b0;
                held        = 0;
                known_total = '0;
                collected   = '0;
                owner       = '0;
                return snapshot(ST_CLEARED);
            end

            if (!active)
            begin
                if (bad || (r.total_length != 0 && seg_end > r.total_length))
                    return snapshot(ST_LENGTH);
                starts[0]   = r.seg_offset;
                sizes[0]    = r.seg_length;
                held        = 1;
                collected   = r.seg_length;
                known_total = r.total_length;
                owner       = r.target_id;
                active      = 1'b1;
                if (r.total_length != 0 && r.seg_length == r.total_length)
                begin
                    active = 1'b0;
                    return snapshot(ST_COMPLETE);
                end
                return snapshot(ST_PENDING);
            end

            if (r.target_id != owner)
                return snapshot(ST_TARGET);
            if (known_total != 0 && r.total_length != known_total)
                return snapshot(ST_LENGTH);
            new_total = (known_total != 0) ? known_total : r.total_length;
            if (bad)
                return snapshot(ST_LENGTH);
            if (new_total != 0)
            begin
                if (seg_end > new_total)
                    return snapshot(ST_LENGTH);
                // a range taken while the total was unknown may already run past it
                if (held > 0 && end_at(held - 1) > new_total)
                    return snapshot(ST_LENGTH);
            end

            slot = held;
            for (i = 0; i < held; i++)
            begin
                s = starts[i];
                e = end_at(i);
                if (s <= r.seg_offset && seg_end <= e)
                    return snapshot(ST_DUP);
                if (r.seg_offset < e && s < seg_end)
                    return snapshot(ST_OVERLAP);
                if (slot == held && s > r.seg_offset)
                    slot = i;
            end

            left  = (slot > 0) && (end_at(slot - 1) == r.seg_offset);
            right = (slot < held) && ({32'd0, starts[slot]} == seg_end);
            if (!left && !right && held >= MAX_SLOTS)
                return snapshot(ST_FULL);

            known_total = new_total;
            if (left && right)
            begin
                sizes[slot - 1] += r.seg_length + sizes[slot];
                for (i = slot; i + 1 < held; i++)
                begin
                    starts[i] = starts[i + 1];
                    sizes[i]  = sizes[i + 1];
                end
                held--;
            end
            else if (left)
            begin
                sizes[slot - 1] += r.seg_length;
            end
            else if (right)
            begin
                starts[slot] = r.seg_offset;
                sizes[slot] += r.seg_length;
            end
            else
            begin
                for (i = held; i > slot; i--)
                begin
                    starts[i] = starts[i - 1];
                    sizes[i]  = sizes[i - 1];
                end
                starts[slot] = r.seg_offset;
                sizes[slot]  = r.seg_length;
                held++;
            end

            collected += r.seg_length;
            if (known_total != 0 && collected == known_total)
            begin
                active = 1'b0;
                return snapshot(ST_COMPLETE);
            end
            return snapshot(ST_PENDING);
        endfunction

        function void note_request(seg_req_t r);
            due_results.push_back(track_segment(r));
        endfunction

        function void check_result(seg_rsp_t got);
            seg_rsp_t want;
            if (due_results.size() == 0)
            begin
                $error("result with no request outstanding: status %0d bytes %0d ranges %0d",
                       got.status, got.received_bytes, got.ranges_held);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.received_bytes !== want.received_bytes)
            begin
                $error("received_bytes: expected %0d, got %0d",
                       want.received_bytes, got.received_bytes);
                errors++;
            end
            if (got.ranges_held !== want.ranges_held)
            begin
                $error("ranges_held: expected %0d, got %0d", want.ranges_held, got.ranges_held);
                errors++;
            end
        endfunction

        function int unsigned outstanding();
            return due_results.size();
        endfunction

    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
// Top-level bench for segment_range_tracker_top: clock, reset, request driver,
// stalling result receiver and the monitor that feeds the scoreboard.
// Depends on srt_pkg, the srt_req_if / srt_rsp_if interfaces and reassembly_tb_pkg.
module tb_top;

    import srt_pkg::*;
    import reassembly_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int LONG_HOLD    = 400;

    logic clk = 1'b0;
    logic rst_n;

    srt_req_if req_ch ();
    srt_rsp_if rsp_ch ();

    reassembly_scoreboard sb;

    int  sent_count    = 0;
    int  burst_left    = 0;
    bit  long_hold_go  = 1'b0;

    segment_range_tracker_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // both channels sampled at the edge, before any update of this step lands
    always @(posedge clk)
    begin : watch
        seg_req_t seen_req;
        seg_rsp_t seen_rsp;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen_req.req_type     = req_ch.req_type;
                seen_req.target_id    = req_ch.target_id;
                seen_req.seg_offset   = req_ch.seg_offset;
                seen_req.seg_length   = req_ch.seg_length;
                seen_req.total_length = req_ch.total_length;
                sb.note_request(seen_req);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                seen_rsp.status         = rsp_ch.status;
                seen_rsp.received_bytes = rsp_ch.received_bytes;
                seen_rsp.ranges_held    = rsp_ch.ranges_held;
                sb.check_result(seen_rsp);
            end
        end
    end

    // result side: phases of steady, random, sparse and patterned ready,
    // plus one long hold-off on request
    initial
    begin : receiver
        bit hold_done;
        int style;
        int span;
        int tick;
        hold_done = 1'b0;
        tick      = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (long_hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(10, 120);
                repeat (span)
                begin
                    tick++;
                    case (style)
                        0:       rsp_ch.ready <= 1'b1;
                        1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                        2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: rsp_ch.ready <= (tick % 3 != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    function automatic seg_req_t add_req(bit [31:0] tid, bit [31:0] off, bit [31:0] len,
                                         bit [31:0] tot);
        seg_req_t r;
        r.req_type     = REQ_ADD;
        r.target_id    = tid;
        r.seg_offset   = off;
        r.seg_length   = len;
        r.total_length = tot;
        return r;
    endfunction

    function automatic void shuffle_reqs(ref seg_req_t q[$]);
        seg_req_t t;
        int       i;
        int       j;
        for (i = q.size() - 1; i > 0; i--)
        begin
            j    = $urandom_range(0, i);
            t    = q[i];
            q[i] = q[j];
            q[j] = t;
        end
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high after
    // acceptance so that a following item goes out back to back.
    task automatic send_req(seg_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= r.req_type;
        req_ch.target_id    <= r.target_id;
        req_ch.seg_offset   <= r.seg_offset;
        req_ch.seg_length   <= r.seg_length;
        req_ch.total_length <= r.total_length;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_clear();
        seg_req_t r;
        r              = add_req($urandom, $urandom, $urandom, $urandom);
        r.req_type     = REQ_CLEAR;
        send_req(r);
    endtask

    // stop offering and let every outstanding result come back
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // One packet cut into pieces, sent out of order. The total may be signalled
    // from some piece on or never; now and then a rejected copy is slipped in,
    // and a few packets are abandoned halfway.
    task automatic send_packet();
        seg_req_t        pieces [$];
        seg_req_t        r;
        bit [31:0]       tid;
        bit [31:0]       total;
        bit [31:0]       len;
        longint unsigned pos;
        longint unsigned rem;
        longint unsigned cap;
        longint unsigned lim;
        int              n;
        int              i;
        int              kind;
        int              known_from;
        int              abort_at;
        bit              unknown;
        bit              adopted;

        tid = $urandom;
        if ($urandom_range(0, 9) < 7)
            total = $urandom_range(1, 300);
        else
        begin
            total = $urandom;
            if (total == 0)
                total = 1;
        end
        n = $urandom_range(1, 12);
        if (total < n)
            n = int'(total);

        pos = 0;
        for (i = 0; i < n; i++)
        begin
            rem = total - pos;
            if (i == n - 1)
                len = rem[31:0];
            else
            begin
                cap = rem - (n - 1 - i);
                lim = 2 * rem / (n - i);
                if (lim > cap)
                    lim = cap;
                if (lim < 1)
                    lim = 1;
                len = $urandom_range(1, lim[31:0]);
            end
            pieces.push_back(add_req(tid, pos[31:0], len, 32'd0));
            pos += len;
        end
        shuffle_reqs(pieces);

        unknown    = ($urandom_range(0, 9) == 0);
        known_from = unknown ? n : $urandom_range(0, n - 1);
        for (i = known_from; i < n; i++)
            pieces[i].total_length = total;
        abort_at = (n > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, n - 1) : n;

        for (i = 0; i < abort_at; i++)
        begin
            if (i > 0 && $urandom_range(0, 7) == 0)
            begin
                adopted        = (known_from < i);
                r              = pieces[$urandom_range(0, i - 1)];
                r.total_length = adopted ? total : 32'd0;
                kind           = $urandom_range(0, 2);
                if (kind == 1)
                    r.target_id = tid ^ ($urandom | 32'd1);
                else if (kind == 2)
                begin
                    if (adopted)
                        r.total_length = total ^ (32'd1 << $urandom_range(0, 31));
                    else
                        r.target_id = tid ^ 32'h8000_0000;
                end
                send_req(r);
            end
            send_req(pieces[i]);
        end
        if (unknown || abort_at < n)
            send_clear();
    endtask

    // Isolated pieces until the table overflows, then the gaps and every isolated
    // piece once more, in random order.
    task automatic fill_table();
        seg_req_t  firsts [$];
        seg_req_t  rest [$];
        bit [31:0] tid;
        bit [31:0] unit;
        bit [31:0] total;
        int        spots;
        int        i;

        tid   = $urandom;
        unit  = $urandom_range(1, 8);
        spots = MAX_SLOTS + 2;
        total = (2 * spots - 1) * unit;
        for (i = 0; i < spots; i++)
        begin
            firsts.push_back(add_req(tid, 2 * i * unit, unit, total));
            rest.push_back(add_req(tid, 2 * i * unit, unit, total));
        end
        for (i = 0; i < spots - 1; i++)
            rest.push_back(add_req(tid, (2 * i + 1) * unit, unit, total));
        shuffle_reqs(firsts);
        shuffle_reqs(rest);
        foreach (firsts[i])
            send_req(firsts[i]);
        foreach (rest[i])
            send_req(rest[i]);
        send_clear();
    endtask

    // small window of colliding segments: overlaps, duplicates, target and
    // total conflicts, stray clears
    task automatic send_tangle();
        seg_req_t  r;
        bit [31:0] tid;
        bit [31:0] tot;
        int        n;
        int        i;
        int        k;

        tid = $urandom;
        n   = $urandom_range(5, 20);
        for (i = 0; i < n; i++)
        begin
            k   = $urandom_range(0, 3);
            tot = (k == 0) ? 32'd0 : (k == 3) ? 32'd80 : 32'd64;
            r   = add_req(($urandom_range(0, 5) == 0) ? tid + 1 : tid,
                          $urandom_range(0, 70), $urandom_range(1, 16), tot);
            if ($urandom_range(0, 19) == 0)
                r.req_type = REQ_CLEAR;
            send_req(r);
        end
        send_clear();
    endtask

    // wide random fields, some running past 32 bits
    task automatic send_noise();
        seg_req_t r;
        int       n;
        int       i;

        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
        begin
            r.req_type     = 1'($urandom_range(0, 1));
            r.target_id    = $urandom;
            r.seg_offset   = $urandom >> $urandom_range(0, 31);
            r.seg_length   = $urandom >> $urandom_range(0, 31);
            r.total_length = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            if (r.seg_length == 0)
                r.seg_length = 1;
            send_req(r);
        end
        send_clear();
    endtask

    initial
    begin : stimulus
        bit hold_asked;
        bit drained_mid;
        int pick;

        hold_asked  = 1'b0;
        drained_mid = 1'b0;
        rst_n = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_ADD;
        req_ch.target_id    <= '0;
        req_ch.seg_offset   <= '0;
        req_ch.seg_length   <= '0;
        req_ch.total_length <= '0;
        sb = new;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, end past 32 bits, single-segment completion
        send_req(add_req(32'h0, 32'h0, 32'd0, 32'd0));
        send_req(add_req(32'h1, 32'hFFFF_FFF0, 32'h20, 32'd0));
        send_req(add_req(32'h2, 32'h0, 32'd100, 32'd100));
        // build up with unknown total: wrong target, duplicate, overlap
        send_req(add_req(32'hFFFF_FFFF, 32'd0, 32'd10, 32'd0));
        send_req(add_req(32'h0, 32'd20, 32'd10, 32'd0));
        send_req(add_req(32'hFFFF_FFFF, 32'd20, 32'd10, 32'd0));
        send_req(add_req(32'hFFFF_FFFF, 32'd2, 32'd3, 32'd0));
        send_req(add_req(32'hFFFF_FFFF, 32'd5, 32'd10, 32'd0));
        // held range already past the newly signalled total
        send_req(add_req(32'hFFFF_FFFF, 32'd10, 32'd5, 32'd25));
        // merge on both sides, then left merge adopting the total
        send_req(add_req(32'hFFFF_FFFF, 32'd10, 32'd10, 32'd0));
        send_req(add_req(32'hFFFF_FFFF, 32'd30, 32'd5, 32'd40));
        // total mismatch, segment past total, then completion
        send_req(add_req(32'hFFFF_FFFF, 32'd35, 32'd5, 32'd41));
        send_req(add_req(32'hFFFF_FFFF, 32'd38, 32'd5, 32'd40));
        send_req(add_req(32'hFFFF_FFFF, 32'd35, 32'd5, 32'd40));
        // top of the address space: right merge and an end one past 32 bits
        send_req(add_req(32'h5A5A_A5A5, 32'hFFFF_FF00, 32'hFF, 32'hFFFF_FFFF));
        send_req(add_req(32'h5A5A_A5A5, 32'hFFFF_FE00, 32'h100, 32'hFFFF_FFFF));
        send_req(add_req(32'h5A5A_A5A5, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF));
        send_clear();
        send_clear();
        // huge segment with the total never known
        send_req(add_req(32'h7, 32'h0, 32'hFFFF_FFFF, 32'd0));
        send_req(add_req(32'h7, 32'h8000_0000, 32'd1, 32'd0));
        send_clear();
        wait_idle();

        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (!hold_asked && sent_count > 700)
            begin
                long_hold_go = 1'b1;
                hold_asked   = 1'b1;
            end
            if (!drained_mid && sent_count > 1200)
            begin
                wait_idle();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 62)
                send_packet();
            else if (pick < 65)
                fill_table();
            else if (pick < 85)
                send_tangle();
            else
                send_noise();
        end
        wait_idle();
        repeat (20) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/srt_pkg.sv
sv/srt_if.sv
sv/srt_cell.sv
sv/segment_range_tracker_top.sv
tb/sv/reassembly_tb_pkg.sv
tb/sv/tb_top.sv
